// ===== rtl/core/cfsbh_pkg.sv =====
// Shared types and constants for the case-folding string bucket hash.
// Used by the controller, the datapath and the top level.
package cfsbh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIV_STEPS = HASH_W;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
  localparam logic [HASH_W-1:0] TABLE_SIZE_RST = 32'd196613;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic hash_upd;
    logic div_start;
    logic div_step;
    logic load_out;
  } cfsbh_cmd_t;

  typedef struct packed {
    logic div_last;
  } cfsbh_sts_t;

  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if ((b >= UPPER_A) && (b <= UPPER_Z)) begin
      r = b + CASE_OFS;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cfsbh_if.sv =====
// Handshake channel interfaces for the bucket hash block.
// Each carries valid, ready and the payload of one transaction.
interface cfsbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;

  modport source (output valid, output char_byte, output last, input ready);
  modport sink (input valid, input char_byte, input last, output ready);
endinterface

interface cfsbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bucket;

  modport source (output valid, output bucket, input ready);
  modport sink (input valid, input bucket, output ready);
endinterface

interface cfsbh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink (input valid, input table_size, output ready);
endinterface

// ===== rtl/core/cfsbh_ctrl.sv =====
// Controller state machine for the bucket hash block.
// Depends on cfsbh_pkg for the command and status structs.
module cfsbh_ctrl import cfsbh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  cfsbh_sts_t sts,
  output cfsbh_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_RUN);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_RUN: begin
        cmd.hash_upd  = accept && !in_last;
        cmd.div_start = accept && in_last;
        if (accept && in_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/cfsbh_dp.sv =====
// Datapath for the bucket hash block: running hash, table size register,
// a bit-serial restoring remainder unit and the result register.
// Depends on cfsbh_pkg for constants, the case fold and the command structs.
module cfsbh_dp import cfsbh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfsbh_cmd_t        cmd,
  output cfsbh_sts_t        sts,
  input  logic [BYTE_W-1:0] char_byte,
  input  logic              cfg_we,
  input  logic [HASH_W-1:0] cfg_data,
  output logic [HASH_W-1:0] bucket
);

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] table_size_r;
  logic [HASH_W-1:0] dvd_r;
  logic [HASH_W-1:0] rem_r;
  logic [HASH_W:0]   rem_sh;
  logic [HASH_W:0]   rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [HASH_W-1:0] bucket_r;

  assign hash_nxt = {hash_r[HASH_W-6:0], 5'b0} + hash_r
                  + {{(HASH_W-BYTE_W){1'b0}}, fold_lower(char_byte)};

  assign rem_sh = {rem_r, dvd_r[HASH_W-1]};

  always_comb begin
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, table_size_r}) begin
      rem_nxt = rem_sh - {1'b0, table_size_r};
    end
  end

  assign sts.div_last = (cnt_r == CNT_LAST);
  assign bucket       = bucket_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r       <= HASH_SEED;
      table_size_r <= TABLE_SIZE_RST;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        table_size_r <= cfg_data;
      end
      if (cmd.hash_upd) begin
        hash_r <= hash_nxt;
      end else if (cmd.div_start) begin
        hash_r <= HASH_SEED;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= hash_nxt;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt[HASH_W-1:0];
    end
    if (cmd.load_out) begin
      bucket_r <= rem_r;
    end
  end

endmodule

// ===== rtl/core/case_folding_string_bucket_hash.sv =====
// Case-folding djb2 bucket hash. A byte that is not the last of a name is folded
// into the running hash. The last byte starts a 32-step bit-serial remainder unit;
// the bucket is loaded when that unit is done and no earlier bucket is still not
// taken, and no further byte is accepted until then.
// Reset is synchronous and active low; it sets the hash to 5381 and the table
// size to 196613, and needs no clearing pass.
module case_folding_string_bucket_hash import cfsbh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cfsbh_in_if.sink   in_ch,
  cfsbh_out_if.source out_ch,
  cfsbh_cfg_if.sink  cfg_ch
);

  cfsbh_cmd_t cmd;
  cfsbh_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  cfsbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfsbh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .char_byte (in_ch.char_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.table_size),
    .bucket    (out_ch.bucket)
  );

endmodule
